[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/uref_pkg.sv]
package uref_pkg;

  // Default ring depth
  localparam int DEFAULT_FIFO_DEPTH = 64;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Receiver status bit positions
  localparam int ST_PARITY_BIT = 0;
  localparam int ST_FRAME_BIT  = 1;
  localparam int ST_IDLE_BIT   = 4;
  localparam int ST_READY_BIT  = 5;

  // Request beat
  typedef struct packed {
    logic       op;
    logic [7:0] status_bits;
    logic [8:0] data_word;
  } req_t;

  // Response beat
  typedef struct packed {
    logic       ok;
    logic [7:0] ev_char;
    logic       ev_has_data;
    logic       ev_break;
    logic       ev_frame_err;
    logic       ev_parity_err;
    logic       ev_idle;
    logic       rx_irq_enable;
    logic [6:0] fill_count;
  } rsp_t;

  // Stored event, 13 bits
  typedef struct packed {
    logic       idle;
    logic       parity;
    logic       frame;
    logic       brk;
    logic       ch_valid;
    logic [7:0] ch;
  } event_t;

  // Classifier verdict for one sample
  typedef struct packed {
    logic   store;
    logic   irq_clear;
    logic   irq_set;
    event_t ev;
  } cls_t;

endpackage

[hw/rtl/uref_classify.sv]
module uref_classify import uref_pkg::*; (
  input  logic [7:0] status_bits,
  input  logic [8:0] data_word,
  output cls_t       cls
);

  logic ready;
  logic frame;
  logic parity;
  logic zero_data;
  logic line_brk;

  assign ready     = status_bits[ST_READY_BIT];
  assign frame     = status_bits[ST_FRAME_BIT];
  assign parity    = status_bits[ST_PARITY_BIT];
  assign zero_data = (data_word == 9'd0);
  // framing error on an all-zero word is a line break
  assign line_brk  = ready && frame && zero_data;

  // Sort the sample into an event; error bits only count with data ready
  always_comb begin
    cls.ev.ch       = ready ? data_word[7:0] : 8'd0;
    cls.ev.ch_valid = ready && !line_brk && !parity;
    cls.ev.brk      = line_brk;
    cls.ev.frame    = ready && ((frame && !zero_data) || parity);
    cls.ev.parity   = ready && parity;
    cls.ev.idle     = status_bits[ST_IDLE_BIT];
    cls.store       = ready || status_bits[ST_IDLE_BIT];
    cls.irq_clear   = line_brk;
    cls.irq_set     = status_bits[ST_IDLE_BIT];
  end

endmodule

[hw/rtl/uart_rx_event_fifo.sv]
// UART receive event FIFO. Each request beat is either a receiver status
// sample or a pop, and yields exactly one response beat. A sample is sorted
// into an event (character, break, framing or parity error, idle line) and
// written into a ring of FIFO_DEPTH entries held in a single-port synchronous
// RAM; a full ring drops its oldest entry. A sample or an empty pop loads the
// response register directly; other pops read the RAM into rd_data first. A
// request is taken only in the idle state, once the response register is free
// or draining. No RAM clear after reset: only written entries are ever read.
`include "assert_macros.svh"

module uart_rx_event_fifo import uref_pkg::*; #(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  output logic req_stall,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_stall
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  state_t        state;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          irq_en;
  logic          irq_next;
  logic          accept;
  logic          is_full;
  logic          do_write;
  logic          do_read;
  logic [CW-1:0] count_after;
  logic          rsp_load;
  rsp_t          rsp_next;
  cls_t          cls;

  event_t        mem [FIFO_DEPTH];
  event_t        rd_data;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  uref_classify u_classify (
    .status_bits (req.status_bits),
    .data_word   (req.data_word),
    .cls         (cls)
  );

  // Handshake and decode
  assign req_stall   = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign accept      = req_valid && !req_stall;
  assign is_full     = (count == CW'(FIFO_DEPTH));
  assign do_write    = accept && (req.op == OP_SAMPLE) && cls.store;
  assign do_read     = accept && (req.op == OP_POP);
  assign count_after = (cls.store && !is_full) ? count + 1'b1 : count;
  // idle sets the enable after any break clear
  assign irq_next    = cls.irq_set ? 1'b1 : (cls.irq_clear ? 1'b0 : irq_en);

  // Event RAM
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_ptr] <= cls.ev;
    end
    if (do_read) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Next response beat: popped event, sample verdict or empty pop
  always_comb begin
    rsp_next = '0;
    rsp_load = 1'b0;
    if (state == ST_READ) begin
      rsp_load               = 1'b1;
      rsp_next.ok            = 1'b1;
      rsp_next.ev_char       = rd_data.ch;
      rsp_next.ev_has_data   = rd_data.ch_valid;
      rsp_next.ev_break      = rd_data.brk;
      rsp_next.ev_frame_err  = rd_data.frame;
      rsp_next.ev_parity_err = rd_data.parity;
      rsp_next.ev_idle       = rd_data.idle;
      rsp_next.rx_irq_enable = irq_en;
      rsp_next.fill_count    = 7'(count);
    end else if (accept && (req.op == OP_SAMPLE)) begin
      rsp_load               = 1'b1;
      rsp_next.ok            = cls.store;
      rsp_next.rx_irq_enable = irq_next;
      rsp_next.fill_count    = 7'(count_after);
    end else if (accept && (count == '0)) begin
      // pop on empty ring
      rsp_load               = 1'b1;
      rsp_next.rx_irq_enable = irq_en;
      rsp_next.fill_count    = 7'(count);
    end
  end

  // Control and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      irq_en    <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.op == OP_SAMPLE) begin
              irq_en <= irq_next;
              if (cls.store) begin
                wr_ptr <= next_slot(wr_ptr);
                // full ring: oldest entry goes
                if (is_full) begin
                  rd_ptr <= next_slot(rd_ptr);
                end else begin
                  count <= count + 1'b1;
                end
              end
            end else if (count != '0) begin
              rd_ptr <= next_slot(rd_ptr);
              count  <= count - 1'b1;
              state  <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Checks
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(FIFO_DEPTH))
  `ASSERT_IMPL(a_read_slot_free, clk, rst, state == ST_READ, !rsp_valid)
  `ASSERT_NEXT(a_empty_pop, clk, rst, do_read && (count == '0), rsp_valid && !rsp.ok)
  `ASSERT_NEXT(a_sample_done, clk, rst, accept && (req.op == OP_SAMPLE),
               rsp_valid && (rsp.ok == $past(cls.store)))

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uref_pkg::*;

  localparam int RING_DEPTH  = DEFAULT_FIFO_DEPTH;
  localparam int CYCLE_LIMIT = 400000;

  // Status byte masks for building samples
  localparam logic [7:0] S_PAR = 8'(1 << ST_PARITY_BIT);
  localparam logic [7:0] S_FRM = 8'(1 << ST_FRAME_BIT);
  localparam logic [7:0] S_IDL = 8'(1 << ST_IDLE_BIT);
  localparam logic [7:0] S_RDY = 8'(1 << ST_READY_BIT);

  logic clk = 1'b0;
  logic rst = 1'b1;
  req_t req = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall = 1'b0;

  uart_rx_event_fifo uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the event ring and interrupt enable
  event_t      shadow_ring [RING_DEPTH];
  int          shadow_wr = 0;
  int          shadow_rd = 0;
  int          shadow_fill = 0;
  logic        shadow_irq_en = 1'b1;

  rsp_t        owed_rsp [$];
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  // Idling control shared by both sides
  bit          steady = 1'b0;
  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Classify one request, update the shadow state, return the due response
  function automatic rsp_t classify_and_update(req_t r);
    rsp_t   o;
    event_t e;
    logic   keep;
    o = '0;
    e = '0;
    keep = 1'b0;
    if (r.op == OP_SAMPLE) begin
      if (r.status_bits[ST_READY_BIT]) begin
        keep = 1'b1;
        e.ch = r.data_word[7:0];
        e.ch_valid = 1'b1;
        if (r.status_bits[ST_FRAME_BIT]) begin
          // framing error on an all-zero word is a break
          if (r.data_word == '0) begin
            e.brk = 1'b1;
            e.ch_valid = 1'b0;
            shadow_irq_en = 1'b0;
          end else begin
            e.frame = 1'b1;
          end
        end
        if (r.status_bits[ST_PARITY_BIT]) begin
          e.parity = 1'b1;
          e.frame = 1'b1;
          e.ch_valid = 1'b0;
        end
      end
      // idle re-enables the interrupt, after any break clear
      if (r.status_bits[ST_IDLE_BIT]) begin
        e.idle = 1'b1;
        keep = 1'b1;
        shadow_irq_en = 1'b1;
      end
      if (keep) begin
        shadow_ring[shadow_wr] = e;
        shadow_wr = (shadow_wr + 1) % RING_DEPTH;
        // full ring: oldest entry goes
        if (shadow_fill < RING_DEPTH) shadow_fill++;
        else shadow_rd = (shadow_rd + 1) % RING_DEPTH;
        o.ok = 1'b1;
      end
    end else if (shadow_fill > 0) begin
      e = shadow_ring[shadow_rd];
      shadow_rd = (shadow_rd + 1) % RING_DEPTH;
      shadow_fill--;
      o.ok = 1'b1;
      o.ev_char = e.ch;
      o.ev_has_data = e.ch_valid;
      o.ev_break = e.brk;
      o.ev_frame_err = e.frame;
      o.ev_parity_err = e.parity;
      o.ev_idle = e.idle;
    end
    o.rx_irq_enable = shadow_irq_en;
    o.fill_count = 7'(shadow_fill);
    return o;
  endfunction

  function automatic req_t mk_sample(logic [7:0] st, logic [8:0] dw);
    req_t r;
    r.op = OP_SAMPLE;
    r.status_bits = st;
    r.data_word = dw;
    return r;
  endfunction

  // Pop with junk in the unused fields
  function automatic req_t mk_pop();
    return {OP_POP, 8'($urandom), 9'($urandom)};
  endfunction

  // Sample that is mostly well formed: data ready, some errors, some idle
  function automatic req_t rand_sample(bit must_store);
    logic [7:0] st;
    logic [8:0] dw;
    st = 8'($urandom);
    st[ST_READY_BIT]  = must_store || ($urandom_range(0, 9) < 8);
    st[ST_IDLE_BIT]   = ($urandom_range(0, 3) == 0);
    st[ST_FRAME_BIT]  = ($urandom_range(0, 3) == 0);
    st[ST_PARITY_BIT] = ($urandom_range(0, 5) == 0);
    dw = ($urandom_range(0, 4) == 0) ? 9'h000 : 9'($urandom);
    return mk_sample(st, dw);
  endfunction

  task automatic flag_error(string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // One request beat; the prediction is taken when the beat is accepted
  task automatic send_beat(req_t r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    owed_rsp.push_back(classify_and_update(r));
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
      if (!steady && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
      end
    end
  end

  // Response checker
  rsp_t want;
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_rsp.size() == 0) begin
        flag_error($sformatf("response with none outstanding: %p", rsp));
      end else begin
        want = owed_rsp.pop_front();
        if (rsp.ok !== want.ok || rsp.ev_char !== want.ev_char ||
            rsp.ev_has_data !== want.ev_has_data ||
            rsp.ev_break !== want.ev_break ||
            rsp.ev_frame_err !== want.ev_frame_err ||
            rsp.ev_parity_err !== want.ev_parity_err ||
            rsp.ev_idle !== want.ev_idle ||
            rsp.rx_irq_enable !== want.rx_irq_enable ||
            rsp.fill_count !== want.fill_count) begin
          flag_error($sformatf("response mismatch: expected %p, got %p", want, rsp));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("uart_rx_event_fifo test failed");
      $finish;
    end
  end

  // Pop on an empty ring straight out of reset
  task automatic test_empty_pop();
    send_beat(mk_pop());
  endtask

  // Each kind of receive event, then read them all back plus one extra pop
  task automatic test_classify();
    send_beat(mk_sample(S_RDY, 9'h041));
    send_beat(mk_sample(S_RDY, 9'h1ff));
    send_beat(mk_sample(S_RDY | S_FRM, 9'h000));          // break
    send_beat(mk_sample(S_RDY | S_FRM | S_IDL, 9'h000));  // break with idle
    send_beat(mk_sample(S_RDY | S_FRM, 9'h100));          // framing, low byte zero
    send_beat(mk_sample(S_RDY | S_PAR, 9'h0a5));
    send_beat(mk_sample(S_RDY | S_PAR | S_FRM, 9'h000));
    send_beat(mk_sample(S_IDL | S_FRM | S_PAR, 9'h155));  // errors without data
    send_beat(mk_sample(8'hcf, 9'h1aa));                  // no ready, no idle
    send_beat(mk_sample(8'hff, 9'h1ff));
    repeat (10) send_beat(mk_pop());
  endtask

  // Fill past the top so the oldest entries drop, then drain past empty
  task automatic test_overflow();
    repeat (RING_DEPTH + 8) send_beat(rand_sample(1'b1));
    repeat (RING_DEPTH + 6) send_beat(mk_pop());
  endtask

  // Receiver holds off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    steady = 1'b1;
    hold_len = 300;
    hold_seq++;
    repeat (30) send_beat(rand_sample(1'b0));
    repeat (10) send_beat(mk_pop());
    steady = 1'b0;
  endtask

  // Mixed traffic, the sample/pop balance shifting from block to block
  task automatic test_random_traffic(int n_blocks);
    int bias;
    for (int b = 0; b < n_blocks; b++) begin
      bias = $urandom_range(15, 90);
      steady = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 99) >= bias) send_beat(mk_pop());
        else if ($urandom_range(0, 19) == 0)
          send_beat(mk_sample(8'($urandom), 9'($urandom)));
        else send_beat(rand_sample(1'b0));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pop();
    test_classify();
    test_overflow();
    test_backpressure();
    test_random_traffic(25);
    req_valid <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("uart_rx_event_fifo test passed");
    end else begin
      $display("uart_rx_event_fifo test failed");
    end
    $finish;
  end

endmodule
